// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short wrappers for the concurrent assertions used across the noise generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mmng_pkg.sv =====
// ----------------------------------------------------------------------------
// mmng_pkg
// Shared types, constants and helper functions of the multi-mode noise
// generator.
// ----------------------------------------------------------------------------
package mmng_pkg;

    // Sample width default and fixed field widths.
    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int PITCH_WIDTH          = 24;
    localparam int RATE_WIDTH           = 32;
    localparam int RNG_WIDTH            = 32;
    localparam int CFG_INDEX_WIDTH      = 4;
    localparam int CFG_DATA_WIDTH       = 32;

    // Rate scaling: (rate * pitch) >> 16.
    localparam int PROD_WIDTH   = RATE_WIDTH + PITCH_WIDTH;
    localparam int SCALE_SHIFT  = 16;
    localparam int SCALED_WIDTH = PROD_WIDTH - SCALE_SHIFT;

    // Crackle probability and hash increment limits.
    localparam logic [SCALED_WIDTH-1:0] PROB_MIN = SCALED_WIDTH'(42950);
    localparam logic [SCALED_WIDTH-1:0] PROB_MAX = SCALED_WIDTH'(64'd3865470566);
    localparam logic [SCALED_WIDTH-1:0] INC_MIN  = SCALED_WIDTH'(4294967);
    localparam logic [SCALED_WIDTH-1:0] INC_MAX  = SCALED_WIDTH'(64'h1_0000_0000);
    localparam int PHASE_WIDTH = 32;

    localparam logic [RNG_WIDTH-1:0] SEED_DEFAULT = 32'd123456789;

    // Pink filter formats: taps Q8.23, coefficients Q0.23.
    localparam int TAP_WIDTH       = 32;
    localparam int COEF_WIDTH      = 24;
    localparam int W23_WIDTH       = 24;
    localparam int FRAC_BITS       = 23;
    localparam int NUM_DECAY_TAPS  = 6;
    localparam int NUM_TERMS       = 8;
    localparam int PINK_SUM_WIDTH  = 35;

    localparam logic signed [COEF_WIDTH-1:0] TAP_DECAY [NUM_DECAY_TAPS] = '{
        24'sd8379045, 24'sd8332572, 24'sd8128561,
        24'sd7268729, 24'sd4613734, -24'sd6388764
    };
    localparam logic signed [COEF_WIDTH-1:0] TAP_GAIN [NUM_DECAY_TAPS] = '{
        24'sd465718, 24'sd629782, 24'sd1290604,
        24'sd2604542, 24'sd4470727, -24'sd141751
    };
    localparam logic signed [COEF_WIDTH-1:0] GAIN_MID  = 24'sd4497972;
    localparam logic signed [COEF_WIDTH-1:0] GAIN_TAP6 = 24'sd972459;
    localparam logic signed [COEF_WIDTH-1:0] GAIN_OUT  = 24'sd922747;

    // Noise modes.
    typedef enum logic [1:0] {
        MODE_WHITE   = 2'd0,
        MODE_PINK    = 2'd1,
        MODE_CRACKLE = 2'd2,
        MODE_HASH    = 2'd3
    } noise_mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_NOISE_MODE   = 4'd0,
        CFG_CRACKLE_RATE = 4'd1,
        CFG_HASH_RATE    = 4'd2,
        CFG_RNG_SEED     = 4'd3
    } cfg_index_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        noise_mode_t           mode;
        logic [RATE_WIDTH-1:0] crackle_rate;
        logic [RATE_WIDTH-1:0] hash_rate;
    } cfg_t;

    // Seed load request from the configuration port.
    typedef struct packed {
        logic                 load;
        logic [RNG_WIDTH-1:0] value;
    } seed_load_t;

    // Control of the generator stage.
    typedef struct packed {
        logic load;
        logic fire;
    } core_ctrl_t;

    // Register enables of the pink output stages.
    typedef struct packed {
        logic load_sum;
        logic load_prod;
        logic load_out;
    } out_ctrl_t;

    // One step of the 13/17/5 xorshift generator.
    function automatic logic [RNG_WIDTH-1:0] xorshift32(input logic [RNG_WIDTH-1:0] x_in);
        logic [RNG_WIDTH-1:0] x;
        x = x_in;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // Fold a 32-bit word down to one byte.
    function automatic logic [7:0] fold_byte(input logic [RNG_WIDTH-1:0] h);
        return h[7:0] ^ h[15:8] ^ h[23:16] ^ h[31:24];
    endfunction

endpackage

// ===== design/multi_mode_noise_generator_unit.sv =====
// A sample passes the input, product, generator, sum and gain registers and then leaves
// the output register. Throughput: one transaction per cycle while out_stall is low; the
// generator stage closes the loop on the xorshift word, pink taps and hash phase in its own
// registers. Reset: rst_n clears all valid flags and the configuration, hash and filter
// state, and loads the generator with the default seed; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_mode_noise_generator_unit
// Noise generator with white, pink, crackle and hash modes behind a six-stage
// valid/stall pipeline: input, rate scale, generator, sum, gain, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_mode_noise_generator_unit #(
    parameter int SAMPLE_WIDTH = mmng_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mmng_pkg::PITCH_WIDTH-1:0]     pitch_mult,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       noise_sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmng_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mmng_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int NUM_STAGES = 6;

    logic [NUM_STAGES-1:0]                                   valid_reg;
    logic [NUM_STAGES-1:0]                                   valid_next;
    logic [NUM_STAGES-1:0]                                   stage_ready;
    mmng_pkg::cfg_t                                          cfg;
    mmng_pkg::seed_load_t                                    seed;
    mmng_pkg::core_ctrl_t                                    core_ctrl;
    mmng_pkg::out_ctrl_t                                     out_ctrl;
    logic [mmng_pkg::SCALED_WIDTH-1:0]                       prob_raw;
    logic [mmng_pkg::SCALED_WIDTH-1:0]                       inc_raw;
    logic signed [SAMPLE_WIDTH-1:0]                          core_sample;
    logic [mmng_pkg::NUM_TERMS-1:0][mmng_pkg::TAP_WIDTH-1:0] core_terms;

    // A stage can load when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Stage enables.
    assign core_ctrl.load     = stage_ready[2];
    assign core_ctrl.fire     = valid_reg[1] && stage_ready[2];
    assign out_ctrl.load_sum  = stage_ready[3];
    assign out_ctrl.load_prod = stage_ready[4];
    assign out_ctrl.load_out  = stage_ready[5];

    mmng_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .seed      (seed)
    );

    mmng_rate_scale u_rate_scale (
        .clk        (clk),
        .load_in    (stage_ready[0]),
        .load_prod  (stage_ready[1]),
        .pitch_mult (pitch_mult),
        .cfg        (cfg),
        .prob_raw   (prob_raw),
        .inc_raw    (inc_raw)
    );

    mmng_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (core_ctrl),
        .cfg      (cfg),
        .seed     (seed),
        .prob_raw (prob_raw),
        .inc_raw  (inc_raw),
        .sample   (core_sample),
        .terms    (core_terms)
    );

    mmng_pink_out #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_pink_out (
        .clk          (clk),
        .ctrl         (out_ctrl),
        .cfg          (cfg),
        .sample_in    (core_sample),
        .terms        (core_terms),
        .noise_sample (noise_sample)
    );

    // An empty input stage never stalls the producer.
    `ASSERT_IMPLY(a_empty_takes, clk, rst_n, !valid_reg[0], !in_stall,
        "input stalled while the input stage is empty")

    // An accepted transaction occupies the input stage.
    `ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && !in_stall, valid_reg[0],
        "accepted transaction lost at the input stage")

    // Output data only ever comes out of the pipeline.
    `ASSERT_IMPLY(a_out_from_pipe, clk, rst_n, out_valid,
        $past(valid_reg[NUM_STAGES-2]) || $past(out_valid),
        "output valid without a transaction behind it")

endmodule

// ===== design/mmng_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mmng_cfg_regs
// Configuration registers: mode, crackle rate and hash rate, plus the seed
// load request that goes straight to the generator.
// ----------------------------------------------------------------------------
module mmng_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmng_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mmng_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output mmng_pkg::cfg_t                       cfg,
    output mmng_pkg::seed_load_t                 seed
);

    mmng_pkg::noise_mode_t                mode_reg;
    logic [mmng_pkg::RATE_WIDTH-1:0]      crackle_rate_reg;
    logic [mmng_pkg::RATE_WIDTH-1:0]      hash_rate_reg;
    logic                                 write_en;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid & cfg_ready;

    // Register file; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= mmng_pkg::MODE_WHITE;
            crackle_rate_reg <= '0;
            hash_rate_reg    <= '0;
        end
        else if (write_en)
        begin
            case (cfg_index)
                mmng_pkg::CFG_NOISE_MODE:
                    mode_reg <= mmng_pkg::noise_mode_t'(cfg_data[1:0]);
                mmng_pkg::CFG_CRACKLE_RATE:
                    crackle_rate_reg <= cfg_data;
                mmng_pkg::CFG_HASH_RATE:
                    hash_rate_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign cfg.mode         = mode_reg;
    assign cfg.crackle_rate = crackle_rate_reg;
    assign cfg.hash_rate    = hash_rate_reg;

    // A zero seed would lock the generator, so it loads as one.
    assign seed.load  = write_en && (cfg_index == mmng_pkg::CFG_RNG_SEED);
    assign seed.value = (cfg_data == '0) ? mmng_pkg::RNG_WIDTH'(1) : cfg_data;

endmodule

// ===== design/mmng_rate_scale.sv =====
// ----------------------------------------------------------------------------
// mmng_rate_scale
// Input register for the pitch multiplier and the two rate multipliers that
// scale the crackle probability and the hash increment.
// ----------------------------------------------------------------------------
module mmng_rate_scale (
    input  logic                                clk,
    input  logic                                load_in,
    input  logic                                load_prod,
    input  logic [mmng_pkg::PITCH_WIDTH-1:0]    pitch_mult,
    input  mmng_pkg::cfg_t                      cfg,
    output logic [mmng_pkg::SCALED_WIDTH-1:0]   prob_raw,
    output logic [mmng_pkg::SCALED_WIDTH-1:0]   inc_raw
);

    logic [mmng_pkg::PITCH_WIDTH-1:0]  pitch_reg;
    logic [mmng_pkg::PROD_WIDTH-1:0]   prob_prod;
    logic [mmng_pkg::PROD_WIDTH-1:0]   inc_prod;
    logic [mmng_pkg::SCALED_WIDTH-1:0] prob_raw_reg;
    logic [mmng_pkg::SCALED_WIDTH-1:0] inc_raw_reg;

    // Both rates are scaled by the same pitch.
    assign prob_prod = mmng_pkg::PROD_WIDTH'(cfg.crackle_rate) *
                       mmng_pkg::PROD_WIDTH'(pitch_reg);
    assign inc_prod  = mmng_pkg::PROD_WIDTH'(cfg.hash_rate) *
                       mmng_pkg::PROD_WIDTH'(pitch_reg);

    // Input and product registers.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            pitch_reg <= pitch_mult;
        end
        if (load_prod)
        begin
            prob_raw_reg <= prob_prod[mmng_pkg::PROD_WIDTH-1:mmng_pkg::SCALE_SHIFT];
            inc_raw_reg  <= inc_prod[mmng_pkg::PROD_WIDTH-1:mmng_pkg::SCALE_SHIFT];
        end
    end

    assign prob_raw = prob_raw_reg;
    assign inc_raw  = inc_raw_reg;

endmodule

// ===== design/mmng_core.sv =====
// ----------------------------------------------------------------------------
// mmng_core
// Generator stage: xorshift state, pink filter taps, hash phase and held
// hash sample. Produces the finished sample for white, crackle and hash
// modes and the eight pink terms for the output stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmng_core #(
    parameter int SAMPLE_WIDTH = mmng_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  mmng_pkg::core_ctrl_t                                 ctrl,
    input  mmng_pkg::cfg_t                                       cfg,
    input  mmng_pkg::seed_load_t                                 seed,
    input  logic [mmng_pkg::SCALED_WIDTH-1:0]                    prob_raw,
    input  logic [mmng_pkg::SCALED_WIDTH-1:0]                    inc_raw,
    output logic signed [SAMPLE_WIDTH-1:0]                       sample,
    output logic [mmng_pkg::NUM_TERMS-1:0][mmng_pkg::TAP_WIDTH-1:0] terms
);

    localparam int TW     = mmng_pkg::TAP_WIDTH;
    localparam int CW     = mmng_pkg::COEF_WIDTH;
    localparam int ACC_W  = TW + CW + 1;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (mmng_pkg::FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] TAP_MAX  = ACC_W'({1'b0, {(TW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] TAP_MIN  = -TAP_MAX - ACC_W'(1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX     = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] NEG_SMAX = -SMAX;

    // One filter tap: round((tap * decay + w * gain) / 2^23), saturated.
    function automatic logic signed [TW-1:0] tap_update(
        input logic signed [TW-1:0] tap,
        input logic signed [CW-1:0] decay,
        input logic signed [mmng_pkg::W23_WIDTH-1:0] w,
        input logic signed [CW-1:0] gain
    );
        logic signed [TW+CW-1:0]                   p_tap;
        logic signed [mmng_pkg::W23_WIDTH+CW-1:0]  p_in;
        logic signed [ACC_W-1:0]                   acc;
        logic signed [ACC_W-1:0]                   shifted;
        p_tap   = tap * decay;
        p_in    = w * gain;
        acc     = ACC_W'(p_tap) + ACC_W'(p_in) + ACC_HALF;
        shifted = acc >>> mmng_pkg::FRAC_BITS;
        if (shifted > TAP_MAX)
            return {1'b0, {(TW-1){1'b1}}};
        else if (shifted < TAP_MIN)
            return {1'b1, {(TW-1){1'b0}}};
        else
            return shifted[TW-1:0];
    endfunction

    logic [mmng_pkg::RNG_WIDTH-1:0]          rng_reg;
    logic [mmng_pkg::RNG_WIDTH-1:0]          rng_next;
    logic signed [TW-1:0]                    tap_reg [mmng_pkg::NUM_DECAY_TAPS+1];
    logic signed [TW-1:0]                    tap_next [mmng_pkg::NUM_DECAY_TAPS+1];
    logic [mmng_pkg::PHASE_WIDTH-1:0]        phase_reg;
    logic [mmng_pkg::PHASE_WIDTH:0]          phase_sum;
    logic signed [SAMPLE_WIDTH-1:0]          held_reg;
    logic signed [SAMPLE_WIDTH-1:0]          held_new;
    logic signed [SAMPLE_WIDTH-1:0]          sample_reg;
    logic signed [SAMPLE_WIDTH-1:0]          sample_next;
    logic [mmng_pkg::NUM_TERMS-1:0][TW-1:0]  terms_reg;
    logic [mmng_pkg::NUM_TERMS-1:0][TW-1:0]  terms_next;

    logic [mmng_pkg::RNG_WIDTH-1:0]          x_first;
    logic [mmng_pkg::RNG_WIDTH-1:0]          x_second;
    logic signed [SAMPLE_WIDTH-1:0]          white;
    logic signed [mmng_pkg::W23_WIDTH-1:0]   w23;
    logic signed [TW-1:0]                    mid_term;
    logic [mmng_pkg::PHASE_WIDTH-1:0]        prob;
    logic [mmng_pkg::PHASE_WIDTH:0]          inc;
    logic                                    hit;
    logic signed [SAMPLE_WIDTH-1:0]          crackle;
    logic                                    wrap;
    logic [7:0]                              folded;
    logic [23:0]                             hash_word;
    logic [SAMPLE_WIDTH-1:0]                 hash_top;

    // Two generator steps; the second is used by crackle and by a hash wrap.
    assign x_first  = mmng_pkg::xorshift32(rng_reg);
    assign x_second = mmng_pkg::xorshift32(x_first);

    // White sample: top bits minus half scale.
    assign white = {~x_first[mmng_pkg::RNG_WIDTH-1],
                    x_first[mmng_pkg::RNG_WIDTH-2 -: SAMPLE_WIDTH-1]};
    assign w23   = mmng_pkg::W23_WIDTH'(white) <<< (mmng_pkg::W23_WIDTH - SAMPLE_WIDTH);

    // Pink filter taps, all in parallel.
    always_comb
    begin
        for (int i = 0; i < mmng_pkg::NUM_DECAY_TAPS; i++)
        begin
            tap_next[i] = tap_update(tap_reg[i], mmng_pkg::TAP_DECAY[i], w23,
                                     mmng_pkg::TAP_GAIN[i]);
        end
        tap_next[mmng_pkg::NUM_DECAY_TAPS] = tap_update('0, '0, w23, mmng_pkg::GAIN_TAP6);
    end

    assign mid_term = tap_update('0, '0, w23, mmng_pkg::GAIN_MID);

    // Terms summed by the output stages: new taps, old last tap, direct term.
    always_comb
    begin
        for (int i = 0; i < mmng_pkg::NUM_DECAY_TAPS; i++)
        begin
            terms_next[i] = tap_next[i];
        end
        terms_next[mmng_pkg::NUM_DECAY_TAPS]     = tap_reg[mmng_pkg::NUM_DECAY_TAPS];
        terms_next[mmng_pkg::NUM_DECAY_TAPS + 1] = mid_term;
    end

    // Crackle: clamped probability against the second draw.
    always_comb
    begin
        if (prob_raw < mmng_pkg::PROB_MIN)
            prob = mmng_pkg::PROB_MIN[mmng_pkg::PHASE_WIDTH-1:0];
        else if (prob_raw > mmng_pkg::PROB_MAX)
            prob = mmng_pkg::PROB_MAX[mmng_pkg::PHASE_WIDTH-1:0];
        else
            prob = prob_raw[mmng_pkg::PHASE_WIDTH-1:0];
    end

    assign hit     = x_second < prob;
    assign crackle = !hit ? '0 :
                     (!white[SAMPLE_WIDTH-1] && (white != '0)) ? SMAX : NEG_SMAX;

    // Hash: phase accumulator with clamped increment; a new draw on wrap.
    always_comb
    begin
        if (inc_raw < mmng_pkg::INC_MIN)
            inc = mmng_pkg::INC_MIN[mmng_pkg::PHASE_WIDTH:0];
        else if (inc_raw > mmng_pkg::INC_MAX)
            inc = mmng_pkg::INC_MAX[mmng_pkg::PHASE_WIDTH:0];
        else
            inc = inc_raw[mmng_pkg::PHASE_WIDTH:0];
    end

    assign phase_sum = {1'b0, phase_reg} + inc;
    assign wrap      = phase_sum[mmng_pkg::PHASE_WIDTH];
    assign folded    = mmng_pkg::fold_byte(x_second);
    assign hash_word = {folded, folded, 8'h00};
    assign hash_top  = hash_word[23 -: SAMPLE_WIDTH];
    assign held_new  = {~hash_top[SAMPLE_WIDTH-1], hash_top[SAMPLE_WIDTH-2:0]};

    // Sample and next generator word by mode.
    always_comb
    begin
        case (cfg.mode)
            mmng_pkg::MODE_WHITE:
            begin
                sample_next = white;
                rng_next    = x_first;
            end
            mmng_pkg::MODE_PINK:
            begin
                sample_next = white;
                rng_next    = x_first;
            end
            mmng_pkg::MODE_CRACKLE:
            begin
                sample_next = crackle;
                rng_next    = x_second;
            end
            mmng_pkg::MODE_HASH:
            begin
                sample_next = wrap ? held_new : held_reg;
                rng_next    = wrap ? x_second : x_first;
            end
            default:
            begin
                sample_next = white;
                rng_next    = x_first;
            end
        endcase
    end

    // Generator state; a seed write takes priority.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg   <= mmng_pkg::SEED_DEFAULT;
            phase_reg <= '0;
            held_reg  <= '0;
            for (int i = 0; i <= mmng_pkg::NUM_DECAY_TAPS; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            if (seed.load)
            begin
                rng_reg <= seed.value;
            end
            else if (ctrl.fire)
            begin
                rng_reg <= rng_next;
            end
            if (ctrl.fire && (cfg.mode == mmng_pkg::MODE_PINK))
            begin
                for (int i = 0; i <= mmng_pkg::NUM_DECAY_TAPS; i++)
                begin
                    tap_reg[i] <= tap_next[i];
                end
            end
            if (ctrl.fire && (cfg.mode == mmng_pkg::MODE_HASH))
            begin
                phase_reg <= phase_sum[mmng_pkg::PHASE_WIDTH-1:0];
                if (wrap)
                begin
                    held_reg <= held_new;
                end
            end
        end
    end

    // Stage output registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sample_reg <= sample_next;
            terms_reg  <= terms_next;
        end
    end

    assign sample = sample_reg;
    assign terms  = terms_reg;

    // The generator word can never reach zero.
    `ASSERT_ALWAYS(a_rng_nonzero, clk, rst_n, rng_reg != '0, "generator word is zero")

    // Every transaction moves the generator on.
    `ASSERT_IMPLY(a_rng_advances, clk, rst_n, $past(ctrl.fire && !seed.load),
        rng_reg != $past(rng_reg), "generator did not advance")

    // A crackle sample is silence or a full-scale impulse.
    `ASSERT_IMPLY(a_crackle_levels, clk, rst_n,
        $past(ctrl.load && (cfg.mode == mmng_pkg::MODE_CRACKLE)),
        (sample_reg == '0) || (sample_reg == SMAX) || (sample_reg == NEG_SMAX),
        "crackle sample out of set")

endmodule

// ===== design/mmng_pink_out.sv =====
// ----------------------------------------------------------------------------
// mmng_pink_out
// Output stages: sum of the pink terms, scaling by the output gain, then
// rounding and saturation. Other modes pass their sample alongside.
// ----------------------------------------------------------------------------
module mmng_pink_out #(
    parameter int SAMPLE_WIDTH = mmng_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                                                    clk,
    input  mmng_pkg::out_ctrl_t                                     ctrl,
    input  mmng_pkg::cfg_t                                          cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]                          sample_in,
    input  logic [mmng_pkg::NUM_TERMS-1:0][mmng_pkg::TAP_WIDTH-1:0] terms,
    output logic signed [SAMPLE_WIDTH-1:0]                          noise_sample
);

    localparam int SUM_W     = mmng_pkg::PINK_SUM_WIDTH;
    localparam int PROD_W    = SUM_W + mmng_pkg::COEF_WIDTH;
    localparam int RND_W     = PROD_W + 1;
    localparam int OUT_SHIFT = mmng_pkg::FRAC_BITS + mmng_pkg::W23_WIDTH - SAMPLE_WIDTH;
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (OUT_SHIFT - 1);
    localparam logic signed [RND_W-1:0] OUT_MAX  = (RND_W'(1) << (SAMPLE_WIDTH - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] OUT_MIN  = -OUT_MAX - RND_W'(1);

    logic signed [SUM_W-1:0]        sum_next;
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [RND_W-1:0]        rounded;
    logic signed [RND_W-1:0]        shifted;
    logic signed [SAMPLE_WIDTH-1:0] pink;
    logic signed [SAMPLE_WIDTH-1:0] sample3_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample4_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_next;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;

    // Adder tree over the eight terms.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < mmng_pkg::NUM_TERMS; i++)
        begin
            sum_next = sum_next + SUM_W'(signed'(terms[i]));
        end
    end

    // Output gain.
    assign prod_next = sum_reg * mmng_pkg::GAIN_OUT;

    // Round half up, rescale to the sample format and saturate.
    assign rounded = RND_W'(prod_reg) + RND_HALF;
    assign shifted = rounded >>> OUT_SHIFT;
    assign pink    = (shifted > OUT_MAX) ? OUT_MAX[SAMPLE_WIDTH-1:0] :
                     (shifted < OUT_MIN) ? OUT_MIN[SAMPLE_WIDTH-1:0] :
                     shifted[SAMPLE_WIDTH-1:0];
    assign out_next = (cfg.mode == mmng_pkg::MODE_PINK) ? pink : sample4_reg;

    // Stage registers; the last one is the output register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            sum_reg     <= sum_next;
            sample3_reg <= sample_in;
        end
        if (ctrl.load_prod)
        begin
            prod_reg    <= prod_next;
            sample4_reg <= sample3_reg;
        end
        if (ctrl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign noise_sample = out_reg;

endmodule
